// ===== rtl/skcg_pkg.sv =====
package skcg_pkg;

	localparam int unsigned REG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 64;

	// register indexes on the write port
	localparam logic [REG_IDX_BITS-1:0] REG_MODE = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_ATTACK = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_REL_LEVEL = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_MAIN_KNEE = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_MAIN_QUAD = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_BOOST_KNEE = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_BOOST_QUAD = 3'd7;

	localparam logic [1:0] MODE_DOWN = 2'd0;

	localparam logic signed [16:0] ONE_Q12 = 17'sd4096;
	localparam logic signed [16:0] LOG_MIN = -17'sd32768;
	localparam int unsigned EXP_STEPS = 10;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] main_knee;
		logic [47:0] main_quad;
		logic [63:0] boost_knee;
		logic [47:0] boost_quad;
	} back_cfg_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_NORM = 8'b0000_0010,
		ST_LOG  = 8'b0000_0100,
		ST_TERM = 8'b0000_1000,
		ST_QUAD = 8'b0001_0000,
		ST_EXPI = 8'b0010_0000,
		ST_EXP  = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} back_state_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		r = 64'd0;
		x = v;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 64'd0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-j) in q1.30, each a floor square root of the one before
	function automatic logic [31:0] exp_factor(input int j);
		logic [63:0] f;
		f = 64'd2 << 30;
		for (int i = 0; i < j; i++)
			f = isqrt64(f << 30);
		return f[31:0];
	endfunction

	// indexed by fraction bit k
	localparam logic [31:0] EXP_FACTOR [EXP_STEPS] = '{
		exp_factor(10), exp_factor(9), exp_factor(8), exp_factor(7), exp_factor(6),
		exp_factor(5), exp_factor(4), exp_factor(3), exp_factor(2), exp_factor(1)
	};

endpackage

// ===== rtl/soft_knee_compressor_gain.sv =====
// envelope follower and soft-knee compressor gain, one word per audio sample
// input side: push a 24-bit sidechain level while full is low
// result side: while empty is low, envelope_level and gain show the oldest
// result, taken with pop
// configuration: wr_en, wr_index and wr_data write one register per cycle;
// the user writes only while the block holds no word in flight, unenforced
// the front registers each word's difference and coefficient, then moves
// the envelope and hands it to a two-entry queue; the back runs a shared
// multiplier through the log (10 squaring steps), up to two knee curves and
// the exp (10 factor steps); a zero envelope skips the log
// how soon a result shows is set by the back sequencer and the number of
// knee steps; the back finishes each word before it takes the next, while
// the front and the queue go on taking words
// when pop is held low the finished word waits in the result register, the
// back holds its next result and the queue fills, then full rises
// reset clears the envelope, the config registers and every word in flight
module soft_knee_compressor_gain #(
	parameter int LEVEL_BITS = 24,
	parameter int COEF_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      push,
	output logic                                      full,
	input  logic [LEVEL_BITS-1:0]                     input_level,
	output logic                                      empty,
	input  logic                                      pop,
	output logic [LEVEL_BITS-1:0]                     envelope_level,
	output logic [23:0]                               gain,
	input  logic                                      wr_en,
	input  logic [skcg_pkg::REG_IDX_BITS-1:0]         wr_index,
	input  logic [skcg_pkg::CFG_DATA_BITS-1:0]        wr_data
);

	logic [1:0]  mode_q;
	logic [15:0] attack_q;
	logic [15:0] release_q;
	logic [23:0] rel_level_q;
	logic [63:0] main_knee_q;
	logic [47:0] main_quad_q;
	logic [63:0] boost_knee_q;
	logic [47:0] boost_quad_q;

	skcg_pkg::back_cfg_t   back_cfg;
	logic                  q_push;
	logic [LEVEL_BITS-1:0] q_wdata;
	logic                  q_pop;
	logic [LEVEL_BITS-1:0] q_rdata;
	logic                  q_full;
	logic                  q_empty;
	logic                  res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			attack_q <= '0;
			release_q <= '0;
			rel_level_q <= '0;
			main_knee_q <= '0;
			main_quad_q <= '0;
			boost_knee_q <= '0;
			boost_quad_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				skcg_pkg::REG_MODE:       mode_q <= wr_data[1:0];
				skcg_pkg::REG_ATTACK:     attack_q <= wr_data[15:0];
				skcg_pkg::REG_RELEASE:    release_q <= wr_data[15:0];
				skcg_pkg::REG_REL_LEVEL:  rel_level_q <= wr_data[23:0];
				skcg_pkg::REG_MAIN_KNEE:  main_knee_q <= wr_data;
				skcg_pkg::REG_MAIN_QUAD:  main_quad_q <= wr_data[47:0];
				skcg_pkg::REG_BOOST_KNEE: boost_knee_q <= wr_data;
				skcg_pkg::REG_BOOST_QUAD: boost_quad_q <= wr_data[47:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		back_cfg.mode = mode_q;
		back_cfg.main_knee = main_knee_q;
		back_cfg.main_quad = main_quad_q;
		back_cfg.boost_knee = boost_knee_q;
		back_cfg.boost_quad = boost_quad_q;
	end

	skcg_front #(
		.LEVEL_BITS(LEVEL_BITS),
		.COEF_BITS(COEF_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.input_level(input_level),
		.attack_coef(attack_q),
		.release_coef(release_q),
		.release_level(rel_level_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	skcg_queue #(
		.W(LEVEL_BITS)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	skcg_back #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(back_cfg),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_data(q_rdata),
		.res_pop(pop),
		.res_valid(res_valid),
		.res_env(envelope_level),
		.res_gain(gain)
	);

	assign empty = !res_valid;

endmodule

// ===== rtl/skcg_queue.sv =====
module skcg_queue #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/skcg_front.sv =====
module skcg_front #(
	parameter int LEVEL_BITS = 24,
	parameter int COEF_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [LEVEL_BITS-1:0] input_level,
	input  logic [15:0]           attack_coef,
	input  logic [15:0]           release_coef,
	input  logic [23:0]           release_level,
	input  logic                  q_full,
	output logic                  q_push,
	output logic [LEVEL_BITS-1:0] q_data
);

	localparam int PW = 16 + LEVEL_BITS + 1;
	localparam logic [31:0] CMAX = (32'd1 << COEF_BITS) - 32'd1;
	localparam logic [PW-1:0] HALF = PW'(1) << (COEF_BITS - 1);

	logic [LEVEL_BITS-1:0] env_q;
	logic                  valid_s1;
	logic                  up_s1;
	logic [LEVEL_BITS-1:0] d_s1;
	logic [15:0]           coef_s1;

	logic                  accept;
	logic                  use_rel;
	logic [15:0]           coef;
	logic [15:0]           coef_sat;
	logic                  up;
	logic [LEVEL_BITS-1:0] d;
	logic [PW-1:0]         sum;
	logic [LEVEL_BITS-1:0] step;
	logic [LEVEL_BITS-1:0] env_new;

	assign full = valid_s1 || q_full;
	assign accept = push && !full;

	always_comb begin
		use_rel = (32'(env_q) > 32'(release_level)) && (input_level <= env_q);
		coef = use_rel ? release_coef : attack_coef;
		coef_sat = (coef > CMAX[15:0]) ? CMAX[15:0] : coef;
		up = (input_level >= env_q);
		d = up ? (input_level - env_q) : (env_q - input_level);
	end

	// registered stage: scale the difference and move the envelope
	always_comb begin
		sum = PW'(coef_s1) * PW'(d_s1) + HALF;
		step = LEVEL_BITS'(sum >> COEF_BITS);
		env_new = up_s1 ? (env_q + step) : (env_q - step);
	end

	assign q_push = valid_s1;
	assign q_data = env_new;

	always_ff @(posedge clk) begin
		if (accept) begin
			up_s1 <= up;
			d_s1 <= d;
			coef_s1 <= coef_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			env_q <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1)
				env_q <= env_new;
		end
	end

endmodule

// ===== rtl/skcg_back.sv =====
module skcg_back #(
	parameter int LEVEL_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  skcg_pkg::back_cfg_t       cfg,
	input  logic                      q_empty,
	output logic                      q_pop,
	input  logic [LEVEL_BITS-1:0]     q_data,
	input  logic                      res_pop,
	output logic                      res_valid,
	output logic [LEVEL_BITS-1:0]     res_env,
	output logic [23:0]               res_gain
);

	skcg_pkg::back_state_t state_q;

	logic [LEVEL_BITS-1:0] env_q;
	logic [4:0]            p_q;
	logic [31:0]           m_q;
	logic [9:0]            frac_q;
	logic [3:0]            cnt_q;
	logic signed [16:0]    lx_q;
	logic                  curve_q;
	logic signed [27:0]    acc_q;
	logic signed [35:0]    qv_q;
	logic                  sat_q;
	logic [5:0]            e_q;
	logic [9:0]            f_q;
	logic                  res_valid_q;
	logic [LEVEL_BITS-1:0] res_env_q;
	logic [23:0]           res_gain_q;

	logic [31:0]        env32;
	logic [4:0]         p;
	logic signed [15:0] ks;
	logic signed [15:0] ke;
	logic signed [15:0] th;
	logic signed [16:0] xr;
	logic signed [16:0] slope;
	logic [47:0]        quad;
	logic signed [15:0] qa;
	logic signed [15:0] qb;
	logic signed [15:0] qc;
	logic signed [15:0] boost;
	logic signed [18:0] diff;
	logic signed [32:0] lx33;
	logic               active;
	logic               on_line;
	logic signed [35:0] ma;
	logic signed [32:0] mb;
	logic signed [68:0] prod;
	logic signed [68:0] line_r;
	logic signed [68:0] quad_r;
	logic signed [68:0] qa_v;
	logic [32:0]        p2;
	logic [9:0]         frac_next;
	logic signed [6:0]  lxi;
	logic signed [27:0] g;
	logic signed [15:0] gc;
	logic [63:0]        rnd;
	logic [5:0]         s;
	logic [63:0]        sh;
	logic               upward;

	assign upward = (cfg.mode != skcg_pkg::MODE_DOWN);
	assign env32 = 32'(env_q);

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++)
			if (env32[i])
				p = 5'(i);
	end

	// curve operands: boost curve when curve_q is low, main curve otherwise
	always_comb begin
		ks = curve_q ? cfg.main_knee[15:0] : cfg.boost_knee[15:0];
		ke = curve_q ? cfg.main_knee[31:16] : cfg.boost_knee[31:16];
		th = curve_q ? cfg.main_knee[47:32] : cfg.boost_knee[47:32];
		xr = {1'b0, cfg.main_knee[63:48]};
		slope = (curve_q && upward) ? (skcg_pkg::ONE_Q12 - xr) : (xr - skcg_pkg::ONE_Q12);
		quad = curve_q ? cfg.main_quad : cfg.boost_quad;
		qa = quad[15:0];
		qb = quad[31:16];
		qc = quad[47:32];
		boost = cfg.boost_knee[63:48];
		diff = {{2{lx_q[16]}}, lx_q} - {{3{th[15]}}, th};
		lx33 = {{16{lx_q[16]}}, lx_q};
		active = (lx_q > ks);
		on_line = (lx_q >= ke);
	end

	// one shared multiplier, operands by step
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			skcg_pkg::ST_LOG: begin
				ma = {4'b0, m_q};
				mb = {1'b0, m_q};
			end
			skcg_pkg::ST_TERM: begin
				if (on_line) begin
					ma = {{19{slope[16]}}, slope};
					mb = {{14{diff[18]}}, diff};
				end else begin
					ma = {{20{qa[15]}}, qa};
					mb = lx33;
				end
			end
			skcg_pkg::ST_QUAD: begin
				ma = qv_q;
				mb = lx33;
			end
			skcg_pkg::ST_EXP: begin
				ma = {4'b0, m_q};
				mb = {1'b0, skcg_pkg::EXP_FACTOR[cnt_q]};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod = ma * mb;
	end

	always_comb begin
		line_r = (prod + 69'sd2048) >>> 12;
		quad_r = (prod + ({{53{qc[15]}}, qc} <<< 20) + 69'sd2097152) >>> 22;
		qa_v = prod + (({{53{qb[15]}}, qb} - 69'sd4096) <<< 10);
		p2 = prod[63:31];
		frac_next = {frac_q[8:0], p2[32]};
		lxi = $signed({2'b0, p_q}) - 7'(LEVEL_BITS);
		g = acc_q + (upward ? {{12{boost[15]}}, boost} : 28'sd0);
		if (g > 28'sd32767)
			gc = 16'sh7FFF;
		else if (g < -28'sd32768)
			gc = 16'sh8000;
		else
			gc = g[15:0];
		rnd = prod[63:0] + 64'h2000_0000;
		s = 6'd42 - e_q;
		sh = ({32'b0, m_q} + (64'd1 << (s - 6'd1))) >> s;
	end

	assign q_pop = (state_q == skcg_pkg::ST_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res_env = res_env_q;
	assign res_gain = res_gain_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			skcg_pkg::ST_IDLE: begin
				if (!q_empty)
					env_q <= q_data;
			end
			skcg_pkg::ST_NORM: begin
				m_q <= env32 << (~p);
				p_q <= p;
				frac_q <= '0;
				cnt_q <= 4'(skcg_pkg::EXP_STEPS - 1);
				lx_q <= skcg_pkg::LOG_MIN;
				curve_q <= !upward;
				acc_q <= '0;
			end
			skcg_pkg::ST_LOG: begin
				m_q <= p2[32] ? p2[32:1] : p2[31:0];
				frac_q <= frac_next;
				cnt_q <= cnt_q - 4'd1;
				lx_q <= {lxi, frac_next};
			end
			skcg_pkg::ST_TERM: begin
				if (active && on_line)
					acc_q <= acc_q + line_r[27:0];
				if (!active || on_line)
					curve_q <= 1'b1;
				qv_q <= qa_v[35:0];
			end
			skcg_pkg::ST_QUAD: begin
				acc_q <= acc_q + quad_r[27:0];
				curve_q <= 1'b1;
			end
			skcg_pkg::ST_EXPI: begin
				sat_q <= (gc >= 16'sd4096);
				e_q <= {~gc[15], gc[14:10]};
				f_q <= gc[9:0];
				m_q <= 32'h4000_0000;
				cnt_q <= 4'(skcg_pkg::EXP_STEPS - 1);
			end
			skcg_pkg::ST_EXP: begin
				if (f_q[cnt_q])
					m_q <= rnd[61:30];
				cnt_q <= cnt_q - 4'd1;
			end
			skcg_pkg::ST_FIN: begin
				if (!res_valid_q) begin
					res_env_q <= env_q;
					res_gain_q <= (sat_q || sh > 64'hFF_FFFF) ? 24'hFF_FFFF : sh[23:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skcg_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (res_pop && res_valid_q)
				res_valid_q <= 1'b0;
			unique case (state_q)
				skcg_pkg::ST_IDLE: begin
					if (!q_empty)
						state_q <= skcg_pkg::ST_NORM;
				end
				skcg_pkg::ST_NORM: begin
					// zero envelope skips the log and takes the floor value
					state_q <= (env_q == '0) ? skcg_pkg::ST_TERM : skcg_pkg::ST_LOG;
				end
				skcg_pkg::ST_LOG: begin
					if (cnt_q == 4'd0)
						state_q <= skcg_pkg::ST_TERM;
				end
				skcg_pkg::ST_TERM: begin
					if (active && !on_line)
						state_q <= skcg_pkg::ST_QUAD;
					else if (curve_q)
						state_q <= skcg_pkg::ST_EXPI;
				end
				skcg_pkg::ST_QUAD: begin
					state_q <= curve_q ? skcg_pkg::ST_EXPI : skcg_pkg::ST_TERM;
				end
				skcg_pkg::ST_EXPI: begin
					state_q <= skcg_pkg::ST_EXP;
				end
				skcg_pkg::ST_EXP: begin
					if (cnt_q == 4'd0)
						state_q <= skcg_pkg::ST_FIN;
				end
				skcg_pkg::ST_FIN: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						state_q <= skcg_pkg::ST_IDLE;
					end
				end
				default: state_q <= skcg_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/skcg_checker.sv =====
module skcg_checker #(
	parameter int LEVEL_BITS = 24
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input logic [LEVEL_BITS-1:0] envelope_level,
	input logic [23:0]           gain
);

	// a waiting word holds until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(envelope_level) && $stable(gain))
		else $error("result word changed while waiting");

	// the front is busy, with full high, in the cycle after each accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("full not raised after accepted word");

	// a single result register: taking a word leaves nothing behind it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> empty)
		else $error("result still shown after pop");

endmodule

bind soft_knee_compressor_gain skcg_checker #(
	.LEVEL_BITS(LEVEL_BITS)
) u_skcg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.push(push),
	.full(full),
	.empty(empty),
	.pop(pop),
	.envelope_level(envelope_level),
	.gain(gain)
);
